// ----- rtl/pse_pkg.sv -----
//------------------------------------------------------------------------------
// pse_pkg
// Shared constants and types for the postfix stack evaluator.
//------------------------------------------------------------------------------
package pse_pkg;

    localparam int unsigned DEFAULT_STACK_DEPTH = 64;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned VALUE_W = 31;
    localparam int unsigned CODE_W = 3;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [CODE_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4
    } op_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // Handshake between the evaluator control and the iterative math unit.
    typedef struct packed {
        logic             start;
        logic [CODE_W-1:0] code;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] value;
        logic              div_zero;
    } alu_rsp_t;

endpackage

// ----- rtl/pse_ram.sv -----
//------------------------------------------------------------------------------
// pse_ram
// Generic single-port-write, single-port-read RAM with registered read data.
//------------------------------------------------------------------------------
module pse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/pse_alu.sv -----
//------------------------------------------------------------------------------
// pse_alu
// Iterative arithmetic unit: add, subtract, multiply, restoring divide and
// square-and-multiply power, one step per cycle for the long operations.
//------------------------------------------------------------------------------
module pse_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  pse_pkg::alu_req_t req,
    output pse_pkg::alu_rsp_t rsp
);
    import pse_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_POW_MUL, S_POW_SQ, S_DONE} state_t;

    state_t            state_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] base_reg;
    logic [DATA_W-1:0] exp_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic [5:0]        cnt_reg;
    logic              neg_reg;
    logic              dz_reg;

    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;
    logic [DATA_W-1:0] prod;

    assign mag_a = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
    assign mag_b = req.b[DATA_W-1] ? (~req.b + 1'b1) : req.b;
    assign rem_shift = {rem_reg, acc_reg[DATA_W-1]};
    assign rem_diff = rem_shift - {1'b0, den_reg};
    assign prod = (state_reg == S_POW_MUL) ? acc_reg * base_reg : base_reg * base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dz_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        dz_reg <= 1'b0;
                        case (req.code)
                            OP_ADD:
                            begin
                                acc_reg   <= req.a + req.b;
                                state_reg <= S_DONE;
                            end
                            OP_SUB:
                            begin
                                acc_reg   <= req.a - req.b;
                                state_reg <= S_DONE;
                            end
                            OP_MUL:
                            begin
                                acc_reg   <= req.a * req.b;
                                state_reg <= S_DONE;
                            end
                            OP_DIV:
                            begin
                                if (req.b == '0)
                                begin
                                    acc_reg   <= '0;
                                    dz_reg    <= 1'b1;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    acc_reg   <= mag_a;
                                    rem_reg   <= '0;
                                    den_reg   <= mag_b;
                                    neg_reg   <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
                                    cnt_reg   <= 6'(DATA_W);
                                    state_reg <= S_DIV;
                                end
                            end
                            OP_POW:
                            begin
                                if (req.b[DATA_W-1])
                                begin
                                    if (req.a == 32'd1)
                                    begin
                                        acc_reg <= 32'd1;
                                    end
                                    else if (req.a == '1)
                                    begin
                                        acc_reg <= req.b[0] ? '1 : 32'd1;
                                    end
                                    else
                                    begin
                                        acc_reg <= '0;
                                        dz_reg  <= (req.a == '0);
                                    end
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    acc_reg   <= 32'd1;
                                    base_reg  <= req.a;
                                    exp_reg   <= req.b;
                                    state_reg <= S_POW_MUL;
                                end
                            end
                            default:
                            begin
                                acc_reg   <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (!rem_diff[DATA_W])
                    begin
                        rem_reg <= rem_diff[DATA_W-1:0];
                        acc_reg <= {acc_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift[DATA_W-1:0];
                        acc_reg <= {acc_reg[DATA_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= S_DONE;
                        if (neg_reg)
                        begin
                            acc_reg <= ~{acc_reg[DATA_W-2:0], !rem_diff[DATA_W]} + 1'b1;
                        end
                    end
                end
                S_POW_MUL:
                begin
                    if (exp_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (exp_reg[0])
                        begin
                            acc_reg <= prod;
                        end
                        state_reg <= S_POW_SQ;
                    end
                end
                S_POW_SQ:
                begin
                    base_reg  <= prod;
                    exp_reg   <= exp_reg >> 1;
                    state_reg <= S_POW_MUL;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = (state_reg == S_DONE);
    assign rsp.value = acc_reg;
    assign rsp.div_zero = dz_reg;

endmodule

// ----- rtl/postfix_stack_evaluator.sv -----
//------------------------------------------------------------------------------
// postfix_stack_evaluator
// Reverse Polish integer evaluator over an operand stack held in a RAM.
//
// Channel | Direction | Handshake      | Payload
// in      | input     | valid / ready  | is_operator, operand_value,
//         |           |                | operator_code, end_of_expression
// out     | output    | out_valid/rdy  | result_value, status
//
// An operand is pushed as it is accepted. An operator reads its operands
// from the stack RAM and waits on the iterative math unit; divide and power
// can run longer than add/sub/mul. The last token adds a read of the top of
// stack. No clearing pass follows reset. Input is not taken while a result
// waits in the output register.
//------------------------------------------------------------------------------
module postfix_stack_evaluator #(
    parameter int unsigned STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    output logic                          ready,
    input  logic                          is_operator,
    input  logic [pse_pkg::VALUE_W-1:0]   operand_value,
    input  logic [pse_pkg::CODE_W-1:0]    operator_code,
    input  logic                          end_of_expression,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [pse_pkg::DATA_W-1:0] result_value,
    output logic [pse_pkg::STATUS_W-1:0]  status
);
    import pse_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_RD_B, S_RD_A, S_ALU, S_WAIT, S_TOP, S_EMIT} state_t;

    state_t            state_reg;
    logic [PW-1:0]     sp_reg;
    logic [1:0]        err_reg;
    logic              last_reg;
    logic [CODE_W-1:0] code_reg;
    logic [DATA_W-1:0] b_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] result_reg;
    logic [1:0]        status_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic              accept;
    logic [PW-1:0]     sp_m1;
    logic [PW-1:0]     sp_m2;

    assign ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept = valid && ready;
    assign sp_m1 = sp_reg - 1'b1;
    assign sp_m2 = sp_reg - 2'd2;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sp_reg[AW-1:0];
        wr_data = {1'b0, operand_value};
        rd_addr = sp_m1[AW-1:0];
        if (accept && !is_operator && sp_reg < PW'(STACK_DEPTH))
        begin
            wr_en = 1'b1;
        end
        if (state_reg == S_RD_B || state_reg == S_RD_A)
        begin
            rd_addr = sp_m2[AW-1:0];
        end
        if (state_reg == S_WAIT && alu_rsp.done)
        begin
            wr_en   = 1'b1;
            wr_addr = sp_m1[AW-1:0];
            wr_data = alu_rsp.value;
        end
    end

    assign alu_req.start = (state_reg == S_ALU);
    assign alu_req.code = code_reg;
    assign alu_req.a = rd_data;
    assign alu_req.b = b_reg;

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pse_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= end_of_expression;
                        code_reg <= operator_code;
                        if (is_operator)
                        begin
                            if (sp_reg < PW'(2))
                            begin
                                if (err_reg == ST_OK)
                                begin
                                    err_reg <= ST_UNDERFLOW;
                                end
                                state_reg <= end_of_expression ? S_TOP : S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_RD_B;
                            end
                        end
                        else
                        begin
                            if (sp_reg < PW'(STACK_DEPTH))
                            begin
                                sp_reg <= sp_reg + 1'b1;
                            end
                            else if (err_reg == ST_OK)
                            begin
                                err_reg <= ST_OVERFLOW;
                            end
                            state_reg <= end_of_expression ? S_TOP : S_IDLE;
                        end
                    end
                end
                S_RD_B:
                begin
                    b_reg     <= rd_data;
                    state_reg <= S_RD_A;
                end
                S_RD_A:
                begin
                    sp_reg    <= sp_m1;
                    state_reg <= S_ALU;
                end
                S_ALU:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (alu_rsp.done)
                    begin
                        if (alu_rsp.div_zero && err_reg == ST_OK)
                        begin
                            err_reg <= ST_DIVZERO;
                        end
                        state_reg <= last_reg ? S_TOP : S_IDLE;
                    end
                end
                S_TOP:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    result_reg    <= (sp_reg == '0) ? '0 : rd_data;
                    status_reg    <= (err_reg != ST_OK) ? err_reg :
                                     ((sp_reg == '0) ? ST_UNDERFLOW : ST_OK);
                    out_valid_reg <= 1'b1;
                    sp_reg        <= '0;
                    err_reg       <= ST_OK;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign result_value = result_reg;
    assign status = status_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !ready)
        else $error("request taken while busy");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |=> (sp_reg == '0 && out_valid))
        else $error("result emit did not clear stack");

endmodule

// ----- tb/tb_postfix_stack_evaluator.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_postfix_stack_evaluator
// Sends postfix token streams to the evaluator, predicts the value and status
// reported after each last token, and compares every result in order. Covers
// all operators, stack underflow and overflow, divide by zero, power corner
// cases and random expressions under varying idle patterns on both sides.
//------------------------------------------------------------------------------
module tb_postfix_stack_evaluator;
    import pse_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  stat;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic valid;
    logic ready;
    logic is_operator;
    logic [VALUE_W-1:0] operand_value;
    logic [CODE_W-1:0] operator_code;
    logic end_of_expression;
    logic out_valid;
    logic out_ready;
    logic signed [DATA_W-1:0] result_value;
    logic [STATUS_W-1:0] status;

    logic [31:0] eval_stack [DEPTH];
    int unsigned eval_sp;
    logic [1:0] eval_err;
    outcome_t pending_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int results_seen;
    int tokens_sent;
    int cycles;

    postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready),
        .is_operator(is_operator), .operand_value(operand_value),
        .operator_code(operator_code), .end_of_expression(end_of_expression),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .status(status)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [31:0] abs32(logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic void flag_error(logic [1:0] code);
        if (eval_err == ST_OK)
            eval_err = code;
    endfunction

    function automatic logic [31:0] compute(logic [31:0] a, logic [31:0] b,
                                            logic [2:0] code);
        logic [31:0] q;
        logic [31:0] acc;
        logic [31:0] base;
        logic [31:0] e;
        case (code)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            OP_DIV:
            begin
                if (b == 0)
                begin
                    flag_error(ST_DIVZERO);
                    return 0;
                end
                q = abs32(a) / abs32(b);
                return (a[31] ^ b[31]) ? (32'd0 - q) : q;
            end
            OP_POW:
            begin
                if (b[31])
                begin
                    if (a == 32'd1)
                        return 1;
                    if (a == 32'hFFFF_FFFF)
                        return b[0] ? 32'hFFFF_FFFF : 32'd1;
                    if (a == 0)
                        flag_error(ST_DIVZERO);
                    return 0;
                end
                acc = 1;
                base = a;
                e = b;
                while (e != 0)
                begin
                    if (e[0])
                        acc = acc * base;
                    base = base * base;
                    e = e >> 1;
                end
                return acc;
            end
            default: return 0;
        endcase
    endfunction

    function automatic void predict_token(logic op, logic [30:0] val, logic [2:0] code,
                                          logic last);
        outcome_t o;
        if (op)
        begin
            if (eval_sp < 2)
                flag_error(ST_UNDERFLOW);
            else
            begin
                eval_stack[eval_sp - 2] = compute(eval_stack[eval_sp - 2],
                                                  eval_stack[eval_sp - 1], code);
                eval_sp--;
            end
        end
        else if (eval_sp >= DEPTH)
            flag_error(ST_OVERFLOW);
        else
        begin
            eval_stack[eval_sp] = {1'b0, val};
            eval_sp++;
        end
        if (last)
        begin
            o.value = (eval_sp > 0) ? eval_stack[eval_sp - 1] : 32'd0;
            if (eval_err != ST_OK)
                o.stat = eval_err;
            else
                o.stat = (eval_sp == 0) ? ST_UNDERFLOW : ST_OK;
            pending_results.push_back(o);
            eval_sp = 0;
            eval_err = ST_OK;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a following request can go back to back.
    task automatic send_token(logic op, logic [30:0] val, logic [2:0] code, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            valid <= 1'b0;
            operand_value <= 31'($urandom);
            @(negedge clk);
        end
        valid <= 1'b1;
        is_operator <= op;
        operand_value <= val;
        operator_code <= code;
        end_of_expression <= last;
        @(posedge clk);
        while (!ready)
            @(posedge clk);
        predict_token(op, val, code, last);
        tokens_sent++;
        @(negedge clk);
    endtask

    task automatic push_val(logic [30:0] v, logic last = 1'b0);
        send_token(1'b0, v, 3'($urandom), last);
    endtask

    task automatic apply_op(logic [2:0] code, logic last = 1'b0);
        send_token(1'b1, 31'($urandom), code, last);
    endtask

    task automatic drain;
        valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    // Builds a negative value on the stack as 0 - v.
    task automatic push_neg(logic [30:0] v);
        push_val(0);
        push_val(v);
        apply_op(OP_SUB);
    endtask

    always @(posedge clk)
    begin
        outcome_t exp_o;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_postfix_stack_evaluator: errors");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h status=%0d", result_value, status);
            end
            else
            begin
                exp_o = pending_results.pop_front();
                if (result_value !== exp_o.value || status !== exp_o.stat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                                 exp_o.value, exp_o.stat, result_value, status);
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic test_operators;
        logic [2:0] c;
        for (int i = 0; i < 8; i++)
        begin
            c = 3'(i);
            push_val(31'd100);
            push_val(31'd7);
            apply_op(c, 1'b1);
        end
    endtask

    task automatic test_extremes;
        push_val(31'h7FFF_FFFF);
        push_val(31'h7FFF_FFFF);
        apply_op(OP_ADD, 1'b1);
        push_val(0, 1'b1);
        push_neg(31'h4000_0000);
        push_val(2);
        apply_op(OP_MUL);
        push_neg(1);
        apply_op(OP_DIV, 1'b1);
        push_val(0);
        push_val(0);
        apply_op(OP_POW, 1'b1);
    endtask

    task automatic test_errors;
        apply_op(OP_ADD, 1'b1);
        push_val(5);
        apply_op(OP_SUB, 1'b1);
        push_val(5);
        push_val(0);
        apply_op(OP_DIV, 1'b1);
        send_token(1'b1, 0, OP_ADD, 1'b0);
        push_val(3, 1'b1);
        push_val(1);
        push_val(2, 1'b1);
        // An empty expression finished by an operator.
        apply_op(OP_MUL, 1'b1);
    endtask

    task automatic test_negative_power;
        push_val(1);
        push_neg(3);
        apply_op(OP_POW, 1'b1);
        push_neg(1);
        push_neg(3);
        apply_op(OP_POW, 1'b1);
        push_neg(1);
        push_neg(4);
        apply_op(OP_POW, 1'b1);
        push_val(0);
        push_neg(2);
        apply_op(OP_POW, 1'b1);
        push_val(5);
        push_neg(2);
        apply_op(OP_POW, 1'b1);
    endtask

    task automatic test_overflow;
        for (int i = 0; i < DEPTH + 2; i++)
            push_val(31'(i + 1));
        apply_op(OP_ADD, 1'b1);
        for (int i = 0; i < DEPTH; i++)
            push_val(31'($urandom));
        for (int i = 0; i < DEPTH - 1; i++)
            apply_op(3'($urandom_range(2)));
        apply_op(OP_ADD, 1'b1);
    endtask

    task automatic random_operand;
        case ($urandom_range(5))
            0: push_val(31'($urandom_range(3)));
            1: push_val(31'h7FFF_FFFF - 31'($urandom_range(3)));
            2: push_val(31'($urandom_range(40)));
            default: push_val(31'($urandom));
        endcase
    endtask

    task automatic random_expression;
        int depth_now;
        int n_ops;
        logic [2:0] c;
        depth_now = 0;
        n_ops = $urandom_range(1, 6);
        random_operand();
        depth_now = 1;
        while (n_ops > 0)
        begin
            if (depth_now < 2 || ($urandom_range(2) == 0 && depth_now < 8))
            begin
                random_operand();
                depth_now++;
            end
            else
            begin
                c = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(4));
                apply_op(c, (n_ops == 1) ? 1'b1 : 1'b0);
                depth_now--;
                n_ops--;
            end
        end
    endtask

    task automatic random_noise;
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_token(1'($urandom), 31'($urandom), 3'($urandom),
                       (i == n - 1) ? 1'b1 : 1'b0);
    endtask

    task automatic test_random(int target);
        int start_count;
        start_count = tokens_sent;
        while (tokens_sent - start_count < target)
        begin
            if ($urandom_range(4) == 0)
                random_noise();
            else
                random_expression();
            if ($urandom_range(60) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        valid = 1'b0;
        is_operator = 1'b0;
        operand_value = '0;
        operator_code = '0;
        end_of_expression = 1'b0;
        out_ready = 1'b0;
        eval_sp = 0;
        eval_err = ST_OK;
        mismatches = 0;
        results_seen = 0;
        tokens_sent = 0;
        cycles = 0;
        send_idle_pct = 18;
        recv_idle_pct = 63;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_operators();
        test_extremes();
        test_errors();
        test_negative_power();
        drain();
        test_overflow();
        test_random(250);
        drain();
        send_idle_pct = 63;
        recv_idle_pct = 18;
        test_random(250);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250);
        drain();

        $display("sent %0d tokens, checked %0d results, %0d mismatches",
                 tokens_sent, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_postfix_stack_evaluator: clean");
        else
            $display("tb_postfix_stack_evaluator: errors");
        $finish;
    end
endmodule
